/* src/vpa_pkg.sv */
package vpa_pkg;

	// Fixed field widths.
	localparam int OUT_W     = 24;
	localparam int CFG_W     = 16;
	localparam int TS_IN_W   = 32;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_SPEED = 1'd1;

	localparam logic [CFG_W-1:0] GAIN_RESET = 16'd512;
	localparam logic [CFG_W-1:0] REF_RESET  = 16'd500;

	localparam int UNITY_GAIN = 256;
	localparam int MS_PER_S   = 1000;
	localparam int OUT_MAX    = 8388607;
	localparam int OUT_MIN    = -8388608;

	// Defaults for the top-level parameters.
	localparam int TIME_WIDTH_DEF    = 32;
	localparam int IDLE_LIMIT_MS_DEF = 500;
	localparam int VALUE_WIDTH_DEF   = 16;

endpackage

/* src/velocity_pointer_accel_top.sv */
// Speed-dependent gain for relative pointer motion.
// Input channel (in_valid/in_stall) carries one pointer event per transfer;
// output channel (out_valid/out_stall) returns exactly one result per event,
// in order. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle, since the block does not
// enforce this. Index 0 is the maximum gain, index 1 the reference speed.
// One restoring divider (one quotient bit per cycle) and one multiplier are
// shared under a small sequencer, and a single event occupies the block:
// in_stall is high from the transfer until the result is in the output register.
// Non-relative events, other axes and long pauses bypass the divider. An event
// whose speed is at or below the reference takes one pass through the divider;
// a scaled event takes up to two passes. The output register frees the input
// side: a new event is taken while the previous result still waits, but the
// next result is held back while out_stall stays high. Reset clears both
// stored event times, loads the register reset values and empties the output
// register.
module velocity_pointer_accel_top
	import vpa_pkg::*;
#(
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
	parameter int IDLE_LIMIT_MS = IDLE_LIMIT_MS_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          is_relative,
	input  logic [1:0]                    axis,
	input  logic signed [VALUE_WIDTH-1:0] delta_in,
	input  logic [TS_IN_W-1:0]            timestamp_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]       delta_out,
	output logic                          was_scaled
);

	localparam int TS_W   = (TIME_WIDTH < TS_IN_W) ? TIME_WIDTH : TS_IN_W;
	localparam int NUM_W  = VALUE_WIDTH + 10;
	localparam int DIV_W  = (NUM_W > 32) ? NUM_W : 32;
	localparam int CNT_W  = $clog2(DIV_W);
	localparam int MA_W   = ((VALUE_WIDTH > CFG_W) ? VALUE_WIDTH : CFG_W) + 1;
	localparam int PW     = MA_W + CFG_W + 1;

	localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
	localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_SCALE = 4'd5;
	localparam logic [3:0] S_FIN   = 4'd6;

	localparam logic [1:0] PH_SPEED = 2'd0;
	localparam logic [1:0] PH_GAIN  = 2'd1;
	localparam logic [1:0] PH_APPLY = 2'd2;

	logic [3:0]                    state_q;
	logic [1:0]                    phase_q;
	logic [CFG_W-1:0]              gain_q;
	logic [CFG_W-1:0]              ref_q;
	logic [TS_W-1:0]               last_x_q;
	logic [TS_W-1:0]               last_y_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0]        aval_q;
	logic [CFG_W-1:0]              dt_q;
	logic [DIV_W-1:0]              quo_q;
	logic [CFG_W-1:0]              rem_q;
	logic [CFG_W-1:0]              dvs_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [MA_W-1:0]        mula_q;
	logic [CFG_W-1:0]              mulb_q;
	logic signed [PW-1:0]          prod_q;
	logic                          scaled_q;
	logic                          out_valid_q;
	logic signed [OUT_W-1:0]       delta_out_q;
	logic                          was_scaled_q;

	logic                          in_xfer;
	logic [TS_W-1:0]               now_t;
	logic [TS_W-1:0]               last_t;
	logic [TS_W-1:0]               dt_full;
	logic                          dt_long;
	logic [VALUE_WIDTH-1:0]        aval_in;
	logic [CFG_W+1:0]              trial;
	logic signed [PW-1:0]          prod_next;
	logic signed [PW-1:0]          prod_adj;
	logic signed [PW-1:0]          prod_div;
	logic signed [OUT_W-1:0]       result;
	logic [CFG_W-1:0]              excess;

	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign delta_out  = delta_out_q;
	assign was_scaled = was_scaled_q;

	always_comb begin
		now_t   = timestamp_ms[TS_W-1:0];
		last_t  = axis[0] ? last_y_q : last_x_q;
		dt_full = (now_t > last_t) ? (now_t - last_t) : TS_W'(1);
		dt_long = dt_full > TS_W'(IDLE_LIMIT_MS);
		aval_in = delta_in[VALUE_WIDTH-1] ? VALUE_WIDTH'(-delta_in) : VALUE_WIDTH'(delta_in);
	end

	// One restoring division step: remainder and next dividend bit against the divisor.
	assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};

	assign prod_next = PW'(mula_q) * PW'($signed({1'b0, mulb_q}));
	assign excess    = quo_q[CFG_W-1:0] - ref_q;

	// Division by 256 truncating toward zero, then saturation to the output range; unscaled events pass through.
	always_comb begin
		prod_adj = prod_q + (prod_q[PW-1] ? PW'(UNITY_GAIN - 1) : PW'(0));
		prod_div = prod_adj >>> 8;
		if (!scaled_q) begin
			result = OUT_W'(val_q);
		end else if (prod_div > SAT_HI) begin
			result = OUT_W'(SAT_HI);
		end else if (prod_div < SAT_LO) begin
			result = OUT_W'(SAT_LO);
		end else begin
			result = prod_div[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			ref_q  <= REF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_GAIN: gain_q <= cfg_data;
				REG_REF_SPEED: ref_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SPEED;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
			scaled_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// A finished event loads the output register whenever it is free or draining.
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						val_q    <= delta_in;
						aval_q   <= aval_in;
						dt_q     <= dt_full[CFG_W-1:0];
						phase_q  <= PH_SPEED;
						scaled_q <= 1'b0;
						if (!is_relative || axis[1]) begin
							state_q <= S_FIN;
						end else begin
							if (axis[0]) begin
								last_y_q <= now_t;
							end else begin
								last_x_q <= now_t;
							end
							state_q <= dt_long ? S_FIN : S_LOAD;
						end
					end
				end
				S_LOAD: begin
					rem_q <= '0;
					cnt_q <= CNT_W'(DIV_W - 1);
					if (phase_q == PH_GAIN) begin
						quo_q <= DIV_W'(prod_q[2*CFG_W-1:0]);
						dvs_q <= ref_q;
					end else begin
						quo_q <= DIV_W'(aval_q) * DIV_W'(MS_PER_S);
						dvs_q <= dt_q;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!trial[CFG_W+1]) begin
						rem_q <= trial[CFG_W-1:0];
						quo_q <= {quo_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[CFG_W-2:0], quo_q[DIV_W-1]};
						quo_q <= {quo_q[DIV_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= (phase_q == PH_GAIN) ? S_SCALE : S_CMP;
					end
				end
				S_CMP: begin
					// quo_q holds the speed here.
					if (quo_q <= DIV_W'(ref_q)) begin
						state_q <= S_FIN;
					end else if (gain_q <= CFG_W'(UNITY_GAIN)) begin
						mula_q  <= MA_W'(val_q);
						mulb_q  <= CFG_W'(UNITY_GAIN);
						phase_q <= PH_APPLY;
						state_q <= S_MUL;
					end else if (quo_q >= DIV_W'({ref_q, 1'b0})) begin
						// An excess of at least the reference speed always clamps to the maximum gain.
						mula_q  <= MA_W'(val_q);
						mulb_q  <= gain_q;
						phase_q <= PH_APPLY;
						state_q <= S_MUL;
					end else begin
						mula_q  <= MA_W'({1'b0, excess});
						mulb_q  <= gain_q - CFG_W'(UNITY_GAIN);
						phase_q <= PH_GAIN;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= prod_next;
					if (phase_q == PH_GAIN) begin
						state_q <= S_LOAD;
					end else begin
						scaled_q <= 1'b1;
						state_q  <= S_FIN;
					end
				end
				S_SCALE: begin
					mula_q  <= MA_W'(val_q);
					mulb_q  <= CFG_W'(UNITY_GAIN) + quo_q[CFG_W-1:0];
					phase_q <= PH_APPLY;
					state_q <= S_MUL;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						delta_out_q  <= result;
						was_scaled_q <= scaled_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import vpa_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int END_SETTLE  = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 20;

	typedef struct packed {
		logic signed [OUT_W-1:0] delta;
		logic                    scaled;
	} motion_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_MAX_GAIN;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    is_relative = 1'b0;
	logic [1:0]              axis = 2'd0;
	logic signed [15:0]      delta_in = '0;
	logic [TS_IN_W-1:0]      timestamp_ms = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [OUT_W-1:0] delta_out;
	logic                    was_scaled;

	// Copy of the block's registers and stored event times; the times advance on accepted relative X/Y events.
	longint      gain_model = GAIN_RESET;
	longint      ref_model = REF_RESET;
	logic [31:0] last_x = '0;
	logic [31:0] last_y = '0;

	motion_t     expected_motion[$];
	int          idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_on = 1'b0;
	logic [31:0] motion_clock = '0;
	int          mismatches = 0;
	int          events_in = 0;
	int          results_seen = 0;
	int          scaled_seen = 0;
	int          reg_writes = 0;
	int          quiet = 0;

	velocity_pointer_accel_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.is_relative(is_relative),
		.axis(axis),
		.delta_in(delta_in),
		.timestamp_ms(timestamp_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.delta_out(delta_out),
		.was_scaled(was_scaled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic motion_t accelerate(input logic rel, input logic [1:0] ax,
		input logic signed [15:0] d, input logic [31:0] ts);
		motion_t     r;
		logic [31:0] prev;
		longint      v, dt, mag, speed, excess, mult, scaled_v;
		v = d;
		r.delta = OUT_W'(v);
		r.scaled = 1'b0;
		if (!rel || ax > 2'd1)
			return r;
		prev = (ax == 2'd0) ? last_x : last_y;
		if (ax == 2'd0)
			last_x = ts;
		else
			last_y = ts;
		// A timestamp that does not move forward counts as one millisecond.
		dt = (ts > prev) ? longint'(ts - prev) : 64'sd1;
		if (dt > IDLE_LIMIT_MS_DEF)
			return r;
		mag = (v < 0) ? -v : v;
		speed = mag * MS_PER_S / dt;
		if (speed <= ref_model)
			return r;
		excess = speed - ref_model;
		mult = UNITY_GAIN + excess * (gain_model - UNITY_GAIN) / ref_model;
		if (mult > gain_model)
			mult = gain_model;
		if (mult < UNITY_GAIN)
			mult = UNITY_GAIN;
		scaled_v = v * mult / UNITY_GAIN;
		if (scaled_v > OUT_MAX)
			scaled_v = OUT_MAX;
		if (scaled_v < OUT_MIN)
			scaled_v = OUT_MIN;
		r.delta = OUT_W'(scaled_v);
		r.scaled = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		motion_t want;
		if (in_valid && !in_stall) begin
			expected_motion.push_back(accelerate(is_relative, axis, delta_in, timestamp_ms));
			events_in++;
		end
		if (out_valid && !out_stall) begin
			results_seen++;
			if (expected_motion.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected transfer, delta_out %0d was_scaled %0b",
						$time, delta_out, was_scaled);
			end else begin
				want = expected_motion.pop_front();
				if (want.scaled)
					scaled_seen++;
				if (delta_out !== want.delta) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: delta_out expected %0d, actual %0d",
							$time, want.delta, delta_out);
				end
				if (was_scaled !== want.scaled) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: was_scaled expected %0b, actual %0b",
							$time, want.scaled, was_scaled);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);
	end

	// Holds the output side off; runs beside the sender, counting its own cycles.
	task automatic hold_receiver(input int cycles);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_on = 1'b0;
	endtask

	task automatic send_event(input logic rel, input logic [1:0] ax,
		input logic signed [15:0] d, input logic [31:0] ts);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		is_relative <= rel;
		axis <= ax;
		delta_in <= d;
		timestamp_ms <= ts;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_drained(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_MAX_GAIN)
			gain_model = value;
		else
			ref_model = (value == 0) ? 1 : value;
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd256;
			2: return 16'hFFFF;
			3: return CFG_W'($urandom_range(257, 1024));
			4: return CFG_W'($urandom);
			default: return GAIN_RESET;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_ref();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return CFG_W'($urandom_range(1, 2000));
			4: return CFG_W'($urandom);
			default: return REF_RESET;
		endcase
	endfunction

	// Mostly steady relative motion on a running clock; the rest is other
	// event kinds and relative events with jumping timestamps.
	task automatic random_event();
		int                 pick;
		logic               rel;
		logic [1:0]         ax;
		logic signed [15:0] d;
		logic [31:0]        ts;
		pick = $urandom_range(99);
		rel = 1'b1;
		ax = 2'($urandom_range(1));
		d = 16'($urandom);
		if (pick < 70) begin
			case ($urandom_range(19))
				0, 1: motion_clock += 0;
				2: motion_clock += $urandom_range(501, 3000);
				3, 4, 5, 6, 7, 8: motion_clock += $urandom_range(21, 500);
				default: motion_clock += $urandom_range(1, 20);
			endcase
			ts = motion_clock;
			case ($urandom_range(9))
				0, 1: d = 16'($urandom);
				2, 3, 4: d = 16'($urandom_range(1000));
				default: d = 16'($urandom_range(30));
			endcase
			if ($urandom_range(1))
				d = -d;
		end else if (pick < 85) begin
			rel = 1'($urandom_range(1));
			ax = rel ? 2'($urandom_range(2, 3)) : 2'($urandom_range(3));
			ts = $urandom;
		end else begin
			if ($urandom_range(1))
				ts = $urandom;
			else
				ts = motion_clock - $urandom_range(50);
			if ($urandom_range(1))
				motion_clock = ts;
		end
		send_event(rel, ax, d, ts);
	endtask

	task automatic test_other_events();
		send_event(1'b0, 2'd0, 16'sd32767, 32'd123);
		send_event(1'b1, 2'd2, -16'sd32768, 32'hFFFF_FFFF);
		send_event(1'b1, 2'd3, -16'sd1, 32'd77);
		send_event(1'b0, 2'd1, -16'sd500, 32'd5);
	endtask

	task automatic test_interval_cases();
		send_event(1'b1, 2'd0, 16'sd0, 32'd0);          // no time passed
		send_event(1'b1, 2'd0, 16'sd1, 32'd1);
		send_event(1'b1, 2'd0, 16'sd32767, 32'd3);
		send_event(1'b1, 2'd0, -16'sd32768, 32'd4);
		send_event(1'b1, 2'd0, 16'sd5, 32'd2);          // time going backwards
		send_event(1'b1, 2'd0, 16'sd100, 32'd502);      // interval right at the idle limit
		send_event(1'b1, 2'd0, 16'sd100, 32'd1003);     // one past the idle limit
		send_event(1'b1, 2'd1, 16'sd3, 32'hFFFF_FFF0);
		send_event(1'b1, 2'd1, 16'sd3, 32'hFFFF_FFF5);
		send_event(1'b1, 2'd1, -16'sd7, 32'hFFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		wait_drained(4);
		write_reg(REG_MAX_GAIN, 16'd0);
		write_reg(REG_REF_SPEED, 16'd0);                // stored as one
		send_event(1'b1, 2'd0, -16'sd2, 32'd1010);      // gain below unity still flags scaling
		wait_drained(4);
		write_reg(REG_MAX_GAIN, 16'hFFFF);
		write_reg(REG_REF_SPEED, 16'hFFFF);
		send_event(1'b1, 2'd0, 16'sd32767, 32'd1011);
		send_event(1'b1, 2'd0, -16'sd32768, 32'd1012);
		send_event(1'b1, 2'd0, 16'sd65, 32'd1013);
		wait_drained(4);
		write_reg(REG_MAX_GAIN, 16'd256);
		write_reg(REG_REF_SPEED, 16'd1);
		send_event(1'b1, 2'd0, 16'sd9, 32'd1020);
		wait_drained(4);
		write_reg(REG_MAX_GAIN, 16'd255);
		write_reg(REG_REF_SPEED, 16'd2);
		send_event(1'b1, 2'd1, -16'sd9, 32'd4);
		wait_drained(4);
		write_reg(REG_MAX_GAIN, GAIN_RESET);
		write_reg(REG_REF_SPEED, REF_RESET);
	endtask

	// The output is held off while events keep coming, so the result register
	// and the engine both fill and the input side has to stall.
	task automatic test_backpressure();
		wait_drained(4);
		idle_pct = 0;
		stall_pct = 0;
		motion_clock = 32'd5000;
		fork
			hold_receiver(HOLD_CYCLES);
		join_none
		repeat (20) begin
			motion_clock += $urandom_range(1, 8);
			send_event(1'b1, 2'($urandom_range(1)), 16'($urandom_range(200)), motion_clock);
		end
		wait_drained(4);
	endtask

	task automatic test_random_traffic();
		int send_mix[4] = '{0, 82, 0, 28};
		int stall_mix[4] = '{0, 0, 82, 28};
		for (int p = 0; p < 4; p++) begin
			for (int blk = 0; blk < 4; blk++) begin
				// Every block starts from an empty pipeline with fresh settings.
				wait_drained(4);
				idle_pct = send_mix[p];
				stall_pct = stall_mix[p];
				write_reg(REG_MAX_GAIN, pick_gain());
				write_reg(REG_REF_SPEED, pick_ref());
				motion_clock = $urandom;
				repeat (100) random_event();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_other_events();
		test_interval_cases();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		wait_drained(END_SETTLE);
		$display("summary: %0d events, %0d results checked, %0d of them scaled",
			events_in, results_seen, scaled_seen);
		$display("summary: %0d register writes, four idling mixes, one long output hold",
			reg_writes);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* files.f */
src/vpa_pkg.sv
src/velocity_pointer_accel_top.sv
test/testbench.sv
